// ----- design/gq_pkg.sv -----
// Package for the gimbal Euler-to-quaternion converter: word types, fixed-point
// constants and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps

package gq_pkg;

  // Field widths of the input and result words
  localparam int ANGLE_BITS = 16;
  localparam int QUAT_BITS  = 16;

  // Default CORDIC depth, and the length of the arctangent table
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 32;

  // Internal datapath: Q31 values with headroom for CORDIC growth and sign
  localparam int CW = 34;

  // Binary angle to half-angle in one-turn = 2^32 units
  localparam int HALF_SHL = 31 - ANGLE_BITS;

  // CORDIC start value of x, the inverse gain in Q31
  localparam logic signed [CW-1:0] GAIN_Q31 = CW'(64'sd1304065748);

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } gq_in_t;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } gq_out_t;

  // One CORDIC lane: cosine, sine and residual angle
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } gq_lane_t;

  // Roll, pitch and yaw lanes travelling together
  typedef struct packed {
    gq_lane_t roll;
    gq_lane_t pitch;
    gq_lane_t yaw;
  } gq_trio_t;

  // arctan(2^-i) in one-turn = 2^32 units
  function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] idx);
    logic signed [CW-1:0] r;
    case (idx)
      5'd0:  r = CW'(64'sd536870912);
      5'd1:  r = CW'(64'sd316933406);
      5'd2:  r = CW'(64'sd167458907);
      5'd3:  r = CW'(64'sd85004756);
      5'd4:  r = CW'(64'sd42667331);
      5'd5:  r = CW'(64'sd21354465);
      5'd6:  r = CW'(64'sd10680862);
      5'd7:  r = CW'(64'sd5340245);
      5'd8:  r = CW'(64'sd2670163);
      5'd9:  r = CW'(64'sd1335087);
      5'd10: r = CW'(64'sd667544);
      5'd11: r = CW'(64'sd333772);
      5'd12: r = CW'(64'sd166886);
      5'd13: r = CW'(64'sd83443);
      5'd14: r = CW'(64'sd41722);
      5'd15: r = CW'(64'sd20861);
      5'd16: r = CW'(64'sd10430);
      5'd17: r = CW'(64'sd5215);
      5'd18: r = CW'(64'sd2608);
      5'd19: r = CW'(64'sd1304);
      5'd20: r = CW'(64'sd652);
      5'd21: r = CW'(64'sd326);
      5'd22: r = CW'(64'sd163);
      5'd23: r = CW'(64'sd81);
      5'd24: r = CW'(64'sd41);
      5'd25: r = CW'(64'sd20);
      5'd26: r = CW'(64'sd10);
      5'd27: r = CW'(64'sd5);
      5'd28: r = CW'(64'sd3);
      5'd29: r = CW'(64'sd1);
      5'd30: r = CW'(64'sd1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/gimbal_euler_to_quaternion.sv -----
// Gimbal Euler-angle to quaternion converter, top level.
// Depends on gq_pkg, gq_cordic_cell and gq_quat_mult.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, in_data_i) takes one word of roll,
//   pitch and yaw binary angles; output channel (out_valid_o, out_stall_i,
//   out_data_o) returns one word of quaternion components in Q1.15.
//   A word is moved on a rising edge with valid high and stall low.
//   A word passes through one register per CORDIC cell, then the pair
//   product, triple product and output registers. Throughput is one word per
//   cycle while the receiver does not stall, set by the cell chain, in
//   which every cell and product stage holds one word of its own.
//   While the receiver stalls, the output word holds; words behind it keep
//   moving up into empty stages, and in_stall_o rises only once every stage
//   is full. Reset empties all stages at once; no word is lost or created.
`timescale 1ns / 1ps

module gimbal_euler_to_quaternion import gq_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  gq_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output gq_out_t out_data_o
);

  localparam int NCELL = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // Binary angle to half angle in one-turn = 2^32 units
  function automatic logic signed [CW-1:0] half_angle(input logic signed [ANGLE_BITS-1:0] a);
    logic signed [CW-1:0] e;
    e = CW'(a);
    return e <<< HALF_SHL;
  endfunction

  function automatic gq_lane_t start_lane(input logic signed [ANGLE_BITS-1:0] a);
    gq_lane_t l;
    l.x = GAIN_Q31;
    l.y = '0;
    l.z = half_angle(a);
    return l;
  endfunction

  logic     vld   [NCELL+1];
  logic     rdy   [NCELL+1];
  gq_trio_t chain [NCELL+1];

  // Head of the chain
  assign vld[0]         = in_valid_i;
  assign chain[0].roll  = start_lane(in_data_i.roll_angle);
  assign chain[0].pitch = start_lane(in_data_i.pitch_angle);
  assign chain[0].yaw   = start_lane(in_data_i.yaw_angle);
  assign in_stall_o     = !rdy[0];

  // CORDIC cell chain
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    gq_cordic_cell #(
      .STAGE(i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (vld[i]),
      .in_data_i  (chain[i]),
      .ready_o    (rdy[i]),
      .out_valid_o(vld[i+1]),
      .out_data_o (chain[i+1]),
      .ready_i    (rdy[i+1])
    );
  end

  // Products, sums and output register
  gq_quat_mult u_mult (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vld[NCELL]),
    .in_data_i  (chain[NCELL]),
    .ready_o    (rdy[NCELL]),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

endmodule

// ----- design/gq_cordic_cell.sv -----
// One rotation-mode CORDIC cell, working roll, pitch and yaw lanes side by side.
// Depends on gq_pkg for the lane types and the arctangent table.
`timescale 1ns / 1ps

module gq_cordic_cell import gq_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  gq_trio_t in_data_i,
  output logic     ready_o,
  output logic     out_valid_o,
  output gq_trio_t out_data_o,
  input  logic     ready_i
);

  localparam logic signed [CW-1:0] ATAN = atan_turn(5'(STAGE));

  logic     valid_q;
  gq_trio_t data_q, data_d;

  // One micro-rotation; direction from the sign of the residual angle
  function automatic gq_lane_t rotate(input gq_lane_t l);
    gq_lane_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = $signed(l.y) >>> STAGE;
    dy = $signed(l.x) >>> STAGE;
    if (!l.z[CW-1]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - ATAN;
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + ATAN;
    end
    return r;
  endfunction

  always_comb begin
    data_d.roll  = rotate(in_data_i.roll);
    data_d.pitch = rotate(in_data_i.pitch);
    data_d.yaw   = rotate(in_data_i.yaw);
  end

  // Cell takes a word when empty or when its own word moves on
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- design/gq_quat_mult.sv -----
// Quaternion product pipeline: pair products, triple products, then sums with
// rounding and saturation into the result word. Depends on gq_pkg.
`timescale 1ns / 1ps

module gq_quat_mult import gq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  gq_trio_t in_data_i,
  output logic     ready_o,
  output logic     out_valid_o,
  output gq_out_t  out_data_o,
  input  logic     out_stall_i
);

  localparam int PW = 2 * CW;
  localparam logic signed [PW-1:0] MUL_RND = PW'(1) <<< 30;
  localparam int OSH = 32 - QUAT_BITS;
  localparam logic signed [CW:0] OUT_RND = (CW + 1)'(1) <<< (OSH - 1);
  localparam logic signed [CW:0] OUT_HI  = ((CW + 1)'(1) <<< (QUAT_BITS - 1)) - 1;
  localparam logic signed [CW:0] OUT_LO  = -OUT_HI - 1;

  // Q31 product, rounded half up
  function automatic logic signed [CW-1:0] mul_q31(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [PW-1:0] p;
    p = (a * b + MUL_RND) >>> 31;
    return p[CW-1:0];
  endfunction

  // Q31 sum to output format: round half up, then clamp
  function automatic logic signed [QUAT_BITS-1:0] to_out(input logic signed [CW:0] s);
    logic signed [CW:0] v;
    v = (s + OUT_RND) >>> OSH;
    if (v > OUT_HI) v = OUT_HI;
    if (v < OUT_LO) v = OUT_LO;
    return v[QUAT_BITS-1:0];
  endfunction

  logic [2:0] v_q;
  logic [2:0] rdy;

  // Stage 1 word
  logic signed [CW-1:0] pcr_q, psr_q, pcsr_q, pscr_q, cy_q, sy_q;
  // Stage 2 word
  logic signed [CW-1:0] t_q [8];
  // Stage 3 word
  gq_out_t out_q, out_d;

  // Ready ripples back from the output register
  assign rdy[2]  = !v_q[2] || !out_stall_i;
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  // Pair products of pitch and roll half-angle terms
  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      pcr_q  <= mul_q31(in_data_i.pitch.x, in_data_i.roll.x);
      psr_q  <= mul_q31(in_data_i.pitch.y, in_data_i.roll.y);
      pcsr_q <= mul_q31(in_data_i.pitch.x, in_data_i.roll.y);
      pscr_q <= mul_q31(in_data_i.pitch.y, in_data_i.roll.x);
      cy_q   <= in_data_i.yaw.x;
      sy_q   <= in_data_i.yaw.y;
    end
  end

  // Triple products with the yaw terms
  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      t_q[0] <= mul_q31(pcr_q, cy_q);
      t_q[1] <= mul_q31(psr_q, sy_q);
      t_q[2] <= mul_q31(pcsr_q, cy_q);
      t_q[3] <= mul_q31(pscr_q, sy_q);
      t_q[4] <= mul_q31(pscr_q, cy_q);
      t_q[5] <= mul_q31(pcsr_q, sy_q);
      t_q[6] <= mul_q31(psr_q, cy_q);
      t_q[7] <= mul_q31(pcr_q, sy_q);
    end
  end

  // Component sums
  always_comb begin
    out_d.quat_w = to_out((CW + 1)'(t_q[0]) - (CW + 1)'(t_q[1]));
    out_d.quat_x = to_out((CW + 1)'(t_q[2]) - (CW + 1)'(t_q[3]));
    out_d.quat_y = to_out((CW + 1)'(t_q[4]) + (CW + 1)'(t_q[5]));
    out_d.quat_z = to_out((CW + 1)'(t_q[6]) + (CW + 1)'(t_q[7]));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[2];
  assign out_data_o  = out_q;

endmodule

// ----- design/gq_checker.sv -----
// Port-level checks for the Euler-to-quaternion converter, bound to the top.
// Depends on gq_pkg and gimbal_euler_to_quaternion.
`timescale 1ns / 1ps

module gq_checker import gq_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_stall_o,
  input gq_in_t  in_data_i,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input gq_out_t out_data_o
);

  // A stalled result word stays and holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed or vanished");

  // A stalled angle word stays offered and holds its value
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled angle word changed or vanished");

  // An empty output stage means the whole pipeline can move
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage empty");

  // An unstalled receiver never back-pressures the input
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with receiver taking words");

  // Reset leaves no result word behind
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result word valid straight after reset");

endmodule

bind gimbal_euler_to_quaternion gq_checker u_gq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for gimbal_euler_to_quaternion: drives angle words,
// predicts each quaternion word in fixed point and checks it at the output.
// Depends on gq_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;
  import gq_pkg::*;

  localparam int  RAND_WORDS   = 400;
  localparam int  LATENCY      = CORDIC_STAGES_DEF + 3;
  localparam int  DRAIN_CYCLES = LATENCY + 20;
  localparam int  CYCLE_LIMIT  = 100000;
  localparam int  QUIET_FROM   = 220;
  localparam int  QUIET_TO     = 300;
  localparam int  HOLD_AT      = 120;
  localparam int  HOLD_CYCLES  = 80;
  localparam int  PAUSE_AT     = 330;
  localparam int  IDLE_PCT     = 19;

  localparam longint CORDIC_GAIN = 64'sd1304065748;
  localparam longint Q31_HALF    = 64'sd1073741824;
  localparam longint Q31_ONE     = 64'sd2147483648;

  // arctan(2^-i), one turn = 2^32
  localparam longint ATAN_TAB [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10680862, 5340245,
    2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  logic    clk_i       = 1'b0;
  logic    rst_ni;
  logic    in_valid_i  = 1'b0;
  logic    in_stall_o;
  gq_in_t  in_data_i   = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  gq_out_t out_data_o;

  gq_in_t  angle_queue [$];
  gq_out_t quat_expected [$];

  int unsigned cycles     = 0;
  int unsigned mismatches = 0;
  int unsigned words_in   = 0;
  int unsigned words_out  = 0;
  bit          in_taken   = 1'b0;
  bit          fed_all    = 1'b0;
  bit          pause_done = 1'b0;
  bit          hold_done  = 1'b0;
  int unsigned hold_left  = 0;

  gimbal_euler_to_quaternion dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point prediction
  // ---------------------------------------------------------------------------

  // Cosine and sine of half a binary angle, Q31, rotation-mode CORDIC
  function automatic void half_sincos(input logic signed [ANGLE_BITS-1:0] ang,
                                      output longint c, output longint s);
    longint x, y, z, dx, dy;
    z = (longint'(ang) * Q31_ONE) >>> ANGLE_BITS;
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES_DEF && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TAB[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TAB[i];
      end
    end
    c = x;
    s = y;
  endfunction

  // Q31 product, rounded half up
  function automatic longint q31_mul(input longint a, input longint b);
    return (a * b + Q31_HALF) >>> 31;
  endfunction

  function automatic longint q31_mul3(input longint a, input longint b, input longint c);
    return q31_mul(q31_mul(a, b), c);
  endfunction

  // Q31 to Q1.15 with round half up and saturation at both ends
  function automatic logic signed [QUAT_BITS-1:0] q31_to_quat(input longint v);
    longint r;
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (QUAT_BITS - 1)) - 1;
    lo = -hi - 1;
    r  = v;
    if (32 - QUAT_BITS > 0)
      r = (r + (64'sd1 <<< (32 - QUAT_BITS - 1))) >>> (32 - QUAT_BITS);
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[QUAT_BITS-1:0];
  endfunction

  function automatic gq_out_t quat_from_angles(input gq_in_t a);
    longint  cr, sr, cp, sp, cy, sy;
    gq_out_t q;
    half_sincos(a.roll_angle,  cr, sr);
    half_sincos(a.pitch_angle, cp, sp);
    half_sincos(a.yaw_angle,   cy, sy);
    q.quat_w = q31_to_quat(q31_mul3(cp, cr, cy) - q31_mul3(sp, sr, sy));
    q.quat_x = q31_to_quat(q31_mul3(cp, sr, cy) - q31_mul3(sp, cr, sy));
    q.quat_y = q31_to_quat(q31_mul3(sp, cr, cy) + q31_mul3(cp, sr, sy));
    q.quat_z = q31_to_quat(q31_mul3(sp, sr, cy) + q31_mul3(cp, cr, sy));
    return q;
  endfunction

  // Mostly uniform; some near +-pi, some near zero where +1.0 saturates
  function automatic logic signed [ANGLE_BITS-1:0] pick_angle();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15)
      return (sel < 8) ? 16'sh8000 + 16'($urandom_range(63))
                       : 16'sh7fff - 16'($urandom_range(63));
    if (sel < 30)
      return 16'($urandom_range(64)) - 16'sd32;
    return 16'($urandom);
  endfunction

  task automatic note_mismatch(input string what);
    $display("tb: mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one word held until taken, random idle cycles between words
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    bit quiet;
    bit idle;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        quiet = (words_in >= QUIET_FROM) && (words_in < QUIET_TO);
        idle  = !quiet && ($urandom_range(99) < IDLE_PCT);
        // one pause until the pipeline has emptied completely
        if (words_in == PAUSE_AT && !pause_done) begin
          if (quat_expected.size() == 0) pause_done = 1'b1;
          else idle = 1'b1;
        end
        if (angle_queue.size() == 0) begin
          fed_all = 1'b1;
          in_valid_i <= 1'b0;
        end else if (idle) begin
          in_valid_i <= 1'b0;
        end else begin
          in_data_i  <= angle_queue.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off to fill the pipeline
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    bit quiet;
    if (rst_ni) begin
      if (words_in >= HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      quiet = (words_out >= QUIET_FROM) && (words_out < QUIET_TO);
      if (hold_left > 0) begin
        hold_left   = hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result words, predicts from accepted angle words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    gq_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        words_out++;
        if (quat_expected.size() == 0) begin
          note_mismatch($sformatf("unexpected word w=%0d x=%0d y=%0d z=%0d",
                                  out_data_o.quat_w, out_data_o.quat_x,
                                  out_data_o.quat_y, out_data_o.quat_z));
        end else begin
          want = quat_expected.pop_front();
          if (out_data_o.quat_w !== want.quat_w)
            note_mismatch($sformatf("word %0d quat_w want %0d got %0d",
                                    words_out, want.quat_w, out_data_o.quat_w));
          if (out_data_o.quat_x !== want.quat_x)
            note_mismatch($sformatf("word %0d quat_x want %0d got %0d",
                                    words_out, want.quat_x, out_data_o.quat_x));
          if (out_data_o.quat_y !== want.quat_y)
            note_mismatch($sformatf("word %0d quat_y want %0d got %0d",
                                    words_out, want.quat_y, out_data_o.quat_y));
          if (out_data_o.quat_z !== want.quat_z)
            note_mismatch($sformatf("word %0d quat_z want %0d got %0d",
                                    words_out, want.quat_z, out_data_o.quat_z));
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        quat_expected.push_back(quat_from_angles(in_data_i));
        words_in++;
      end
    end
  end

  // Run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    gq_in_t w;

    // reset goes low after every process waits on it, so its edge is seen
    rst_ni <= 1'b0;

    // directed: zero, both ends of every field, quarter turns, gimbal lock
    angle_queue.push_back('{16'sd0,      16'sd0,      16'sd0});
    angle_queue.push_back('{16'sd32767,  16'sd32767,  16'sd32767});
    angle_queue.push_back('{-16'sd32768, -16'sd32768, -16'sd32768});
    angle_queue.push_back('{-16'sd32768, 16'sd0,      16'sd0});
    angle_queue.push_back('{16'sd0,      -16'sd32768, 16'sd0});
    angle_queue.push_back('{16'sd0,      16'sd0,      -16'sd32768});
    angle_queue.push_back('{16'sd32767,  16'sd0,      16'sd0});
    angle_queue.push_back('{16'sd0,      16'sd32767,  16'sd0});
    angle_queue.push_back('{16'sd0,      16'sd0,      16'sd32767});
    angle_queue.push_back('{16'sd16384,  16'sd0,      16'sd0});
    angle_queue.push_back('{16'sd0,      16'sd16384,  16'sd0});
    angle_queue.push_back('{16'sd0,      -16'sd16384, 16'sd0});
    angle_queue.push_back('{16'sd0,      16'sd0,      16'sd16384});
    angle_queue.push_back('{-16'sd16384, 16'sd16384,  -16'sd16384});
    angle_queue.push_back('{16'sd8192,   16'sd8192,   16'sd8192});
    angle_queue.push_back('{16'sd1,      -16'sd1,     16'sd1});
    angle_queue.push_back('{-16'sd1,     16'sd1,      -16'sd1});
    angle_queue.push_back('{-16'sd32768, 16'sd32767,  -16'sd32768});
    angle_queue.push_back('{16'sd32767,  -16'sd32768, 16'sd32767});
    angle_queue.push_back('{16'sd12345,  -16'sd23456, 16'sd30000});

    // random words
    repeat (RAND_WORDS) begin
      w.roll_angle  = pick_angle();
      w.pitch_angle = pick_angle();
      w.yaw_angle   = pick_angle();
      angle_queue.push_back(w);
    end

    // reset asserted, then released at a falling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!fed_all || quat_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && quat_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
